FILE: rtl/fba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// File table allocator package
// Shared types, status codes and sizing constants for the file table block
// allocator and its submodules.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int DEF_NUM_BLOCKS  = 256;
  localparam int DEF_NUM_ENTRIES = 64;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 31;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 6;
  localparam int BLOCK_W  = 8;

  // Entries in each of the two request queues.
  localparam int QUEUE_DEPTH = 2;

  // Registered stages in a lowest-index finder.
  localparam int FIND_LAT = 3;

  // Bit group that one finder step resolves.
  localparam int GROUP_W = 32;

  // Blocks 0 and 1 are reserved and always marked in use after a format.
  localparam logic [1:0] RESERVED_BLOCKS = 2'b11;

  typedef enum logic [KIND_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_FORMAT = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_EXISTS    = 3'd2,
    STAT_NO_BLOCK  = 3'd3,
    STAT_NO_ENTRY  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_READ,
    S_EXEC
  } eng_state_t;

  typedef struct packed {
    op_t             op;
    logic            search;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [BLOCK_W-1:0] blk;
  } res_t;

endpackage

FILE: rtl/fba_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fba_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Small request queue
// Two-entry flop queue with push/full and pop/empty handshakes.
// ----------------------------------------------------------------------------
module fba_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int DEPTH = fba_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             push_ok;
  logic             pop_ok;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign push_ok = push && !full;
  assign pop_ok  = pop && !empty;
  assign dout    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        count <= count + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/fba_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator front end
// Takes requests, decodes the operation and marks whether the request needs
// the table searches, then queues it for the execution engine.
// ----------------------------------------------------------------------------
module fba_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [fba_pkg::KIND_W-1:0]    kind,
  input  logic [fba_pkg::ID_W-1:0]      file_id,
  input  logic                          cmd_pop,
  output logic                          cmd_valid,
  output fba_pkg::cmd_t                 cmd
);

  fba_pkg::cmd_t                   cmd_in;
  logic [$bits(fba_pkg::cmd_t)-1:0] cmd_raw;
  logic                            cmd_empty;

  // The kind field encodes the operation directly. A format touches only the
  // maps and so skips the search phase.
  always_comb begin
    cmd_in.op     = fba_pkg::op_t'(kind);
    cmd_in.search = (cmd_in.op != fba_pkg::OP_FORMAT);
    cmd_in.id     = file_id;
  end

  fba_fifo #(
    .WIDTH ($bits(fba_pkg::cmd_t))
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .dout  (cmd_raw),
    .empty (cmd_empty)
  );

  assign cmd       = fba_pkg::cmd_t'(cmd_raw);
  assign cmd_valid = !cmd_empty;

endmodule

FILE: rtl/fba_find.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lowest-index finder
// Three-stage registered priority encoder: group summary, group select, then
// bit select inside the chosen group.
// ----------------------------------------------------------------------------
module fba_find #(
  parameter int N = 64,
  localparam int IW = (N > 1) ? $clog2(N) : 1
) (
  input  logic          clk,
  input  logic [N-1:0]  vec,
  output logic          found,
  output logic [IW-1:0] idx
);

  localparam int GW  = fba_pkg::GROUP_W;
  localparam int NG  = (N + GW - 1) / GW;
  localparam int PW  = NG * GW;
  localparam int GSW = (NG > 1) ? $clog2(NG) : 1;
  localparam int BPW = $clog2(GW);

  logic [PW-1:0]  vec_q;
  logic [NG-1:0]  grp_q;
  logic [GSW-1:0] gsel_c;
  logic           gfound_c;
  logic [GSW-1:0] gsel_q;
  logic           gfound_q;
  logic [GW-1:0]  word_c;
  logic [BPW-1:0] pos_c;

  // Stage 1: capture the vector and flag the groups that hold a set bit.
  always_ff @(posedge clk) begin
    vec_q <= PW'(vec);
    for (int g = 0; g < NG; g++) begin
      grp_q[g] <= |PW'(vec) >> 0 == 1'b0 ? 1'b0 : |(PW'(vec) >> (g * GW) & PW'({GW{1'b1}}));
    end
  end

  // Stage 2: lowest group with a set bit.
  always_comb begin
    gsel_c   = '0;
    gfound_c = 1'b0;
    for (int g = NG - 1; g >= 0; g--) begin
      if (grp_q[g]) begin
        gsel_c   = GSW'(g);
        gfound_c = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    gsel_q   <= gsel_c;
    gfound_q <= gfound_c;
  end

  // Stage 3: lowest set bit inside the chosen group.
  always_comb begin
    word_c = vec_q[gsel_q * GW +: GW];
    pos_c  = '0;
    for (int b = GW - 1; b >= 0; b--) begin
      if (word_c[b]) begin
        pos_c = BPW'(b);
      end
    end
  end

  always_ff @(posedge clk) begin
    found <= gfound_q;
    idx   <= IW'({gsel_q, pos_c});
  end

endmodule

FILE: rtl/fba_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator execution engine
// Holds the block map, the entry table and its block RAM, runs the three
// lowest-index searches and applies each request.
// ----------------------------------------------------------------------------
module fba_engine #(
  parameter int NUM_BLOCKS  = fba_pkg::DEF_NUM_BLOCKS,
  parameter int NUM_ENTRIES = fba_pkg::DEF_NUM_ENTRIES
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  fba_pkg::cmd_t cmd,
  output logic          cmd_pop,
  input  logic          res_full,
  output logic          res_push,
  output fba_pkg::res_t res
);

  localparam int EW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
  localparam int BW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam logic [NUM_BLOCKS-1:0] BLK_RESET = NUM_BLOCKS'(fba_pkg::RESERVED_BLOCKS);

  fba_pkg::eng_state_t state;
  fba_pkg::eng_state_t state_next;
  logic [1:0]          cnt;
  fba_pkg::cmd_t       cmd_q;

  logic [NUM_BLOCKS-1:0]     block_in_use;
  logic [NUM_ENTRIES-1:0]    entry_valid;
  logic [fba_pkg::ID_W-1:0]  entry_id [NUM_ENTRIES];
  logic [NUM_ENTRIES-1:0]    match_vec;

  logic          id_found;
  logic [EW-1:0] id_idx;
  logic          blk_found;
  logic [BW-1:0] blk_idx;
  logic          ent_found;
  logic [EW-1:0] ent_idx;
  logic [BW-1:0] ram_rdata;

  logic create_go;
  logic delete_go;
  logic format_go;

  // Match vector: one comparator per table entry.
  always_comb begin
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      match_vec[i] = entry_valid[i] && (entry_id[i] == cmd_q.id);
    end
  end

  fba_find #(.N(NUM_ENTRIES)) u_find_id (
    .clk   (clk),
    .vec   (match_vec),
    .found (id_found),
    .idx   (id_idx)
  );

  fba_find #(.N(NUM_BLOCKS)) u_find_blk (
    .clk   (clk),
    .vec   (~block_in_use),
    .found (blk_found),
    .idx   (blk_idx)
  );

  fba_find #(.N(NUM_ENTRIES)) u_find_ent (
    .clk   (clk),
    .vec   (~entry_valid),
    .found (ent_found),
    .idx   (ent_idx)
  );

  // Block number of each entry; read at the matched slot.
  fba_ram #(
    .WIDTH (BW),
    .DEPTH (NUM_ENTRIES)
  ) u_blk_ram (
    .clk   (clk),
    .we    (create_go),
    .waddr (ent_idx),
    .wdata (blk_idx),
    .raddr (id_idx),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      fba_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = cmd.search ? fba_pkg::S_SRCH : fba_pkg::S_EXEC;
        end
      end
      fba_pkg::S_SRCH: begin
        if (cnt == 2'(fba_pkg::FIND_LAT - 1)) begin
          state_next = fba_pkg::S_READ;
        end
      end
      fba_pkg::S_READ: begin
        state_next = fba_pkg::S_EXEC;
      end
      fba_pkg::S_EXEC: begin
        if (!res_full) begin
          state_next = fba_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = fba_pkg::S_IDLE;
      end
    endcase
  end

  // Outputs and update strobes.
  always_comb begin
    cmd_pop   = 1'b0;
    res_push  = 1'b0;
    create_go = 1'b0;
    delete_go = 1'b0;
    format_go = 1'b0;
    res       = '0;
    unique case (state)
      fba_pkg::S_IDLE: begin
        cmd_pop = cmd_valid;
      end
      fba_pkg::S_EXEC: begin
        if (!res_full) begin
          res_push = 1'b1;
          case (cmd_q.op)
            fba_pkg::OP_CREATE: begin
              if (id_found) begin
                res.status = fba_pkg::STAT_EXISTS;
              end else if (!blk_found) begin
                res.status = fba_pkg::STAT_NO_BLOCK;
              end else if (!ent_found) begin
                res.status = fba_pkg::STAT_NO_ENTRY;
              end else begin
                create_go = 1'b1;
                res.slot  = fba_pkg::SLOT_W'(ent_idx);
                res.blk   = fba_pkg::BLOCK_W'(blk_idx);
              end
            end
            fba_pkg::OP_DELETE, fba_pkg::OP_LOOKUP: begin
              if (!id_found) begin
                res.status = fba_pkg::STAT_NOT_FOUND;
              end else begin
                delete_go = (cmd_q.op == fba_pkg::OP_DELETE);
                res.slot  = fba_pkg::SLOT_W'(id_idx);
                res.blk   = fba_pkg::BLOCK_W'(ram_rdata);
              end
            end
            default: begin
              format_go = 1'b1;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == fba_pkg::S_SRCH) ? cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cmd_q <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || format_go) begin
      block_in_use <= BLK_RESET;
      entry_valid  <= '0;
    end else begin
      if (create_go) begin
        block_in_use[blk_idx] <= 1'b1;
        entry_valid[ent_idx]  <= 1'b1;
      end
      if (delete_go) begin
        block_in_use[ram_rdata] <= 1'b0;
        entry_valid[id_idx]     <= 1'b0;
      end
    end
  end

  // Id cells are only compared while their entry is valid.
  always_ff @(posedge clk) begin
    if (create_go) begin
      entry_id[ent_idx] <= cmd_q.id;
    end
  end

endmodule

FILE: rtl/file_table_block_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// File table block allocator
// Keeps a free-block map and a table of file entries and serves create,
// delete, lookup and format requests, one result per request.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake          Payload
//   -------   ----------------   -------------------------------------
//   request   push / full        kind, file_id
//   result    pop / empty        status, entry_slot, data_block
//
// A create, delete or lookup passes through the engine in order: it takes the
// request from the command queue, goes through the registered lowest-index
// finders, reads the block RAM at the matched slot, then updates the maps and
// posts the result. A format skips the finders and the RAM read.
// Reset is synchronous; the block map and entry valid bits are flops and are
// restored in the reset cycle itself, so no clearing pass follows.
// A full result queue holds the engine in its final step; the command queue
// still takes up to two more requests before full rises.
//
module file_table_block_allocator #(
  parameter int NUM_BLOCKS  = fba_pkg::DEF_NUM_BLOCKS,
  parameter int NUM_ENTRIES = fba_pkg::DEF_NUM_ENTRIES
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [fba_pkg::KIND_W-1:0]     kind,
  input  logic [fba_pkg::ID_W-1:0]       file_id,
  output logic                           empty,
  input  logic                           pop,
  output logic [fba_pkg::STATUS_W-1:0]   status,
  output logic [fba_pkg::SLOT_W-1:0]     entry_slot,
  output logic [fba_pkg::BLOCK_W-1:0]    data_block
);

  // Requests in flight: both queues plus the one held by the engine.
  localparam int MAX_PENDING = 2 * fba_pkg::QUEUE_DEPTH + 1;
  localparam int PDW         = $clog2(MAX_PENDING + 1);

  logic                             cmd_valid;
  logic                             cmd_pop;
  fba_pkg::cmd_t                    cmd;
  logic                             res_full;
  logic                             res_push;
  fba_pkg::res_t                    res_in;
  fba_pkg::res_t                    res_out;
  logic [$bits(fba_pkg::res_t)-1:0] res_raw;
  logic [PDW-1:0]                   pending;

  // Front end: decode and queue incoming requests.
  fba_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .kind      (kind),
    .file_id   (file_id),
    .cmd_pop   (cmd_pop),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Back end: searches the maps and applies each request in order.
  fba_engine #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .NUM_ENTRIES (NUM_ENTRIES)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  // Result queue decouples the engine from the consumer.
  fba_fifo #(
    .WIDTH ($bits(fba_pkg::res_t))
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_raw),
    .empty (empty)
  );

  assign res_out    = fba_pkg::res_t'(res_raw);
  assign status     = res_out.status;
  assign entry_slot = res_out.slot;
  assign data_block = res_out.blk;

  // Count of requests taken whose results have not yet been popped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      case ({push && !full, pop && !empty})
        2'b10:   pending <= pending + 1'b1;
        2'b01:   pending <= pending - 1'b1;
        default: pending <= pending;
      endcase
    end
  end

  // A result is only visible when some request is still owed one.
  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (pending != '0))
    else $error("result shown with no request outstanding");

  // The queues and the engine never hold more requests than they have room for.
  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= PDW'(MAX_PENDING))
    else $error("more requests in flight than storage allows");

  // Reset leaves both channels quiet and open.
  a_reset_state: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not cleared by reset");

endmodule
